### rtl/kmp_substring_search_top_defines.svh
// assertion macros shared by the kmp search rtl
`ifndef KMP_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define KMP_SUBSTRING_SEARCH_TOP_DEFINES_SVH
// property checked on every rising clock edge outside reset
`define KMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`endif

### rtl/kmps_pkg.sv
// shared types and constants of the kmp search block
`default_nettype none
package kmps_pkg;
  localparam int unsigned MaxLen = 256;
  localparam int unsigned IdxW = $clog2(MaxLen);
  localparam int unsigned LenW = IdxW + 1;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    FuncClear = 2'd0,
    FuncPat   = 2'd1,
    FuncText  = 2'd2,
    FuncEnd   = 2'd3
  } func_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data;
  } cmd_t;
endpackage
`default_nettype wire

### rtl/kmps_front.sv
// front end: command queue between the port and the engine
`default_nettype none
module kmps_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  kmps_pkg::cmd_t      cmd_i,
  output logic                full_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output kmps_pkg::cmd_t      cmd_o
);
  `include "kmp_substring_search_top_defines.svh"

  kmps_pkg::cmd_t mem_q [kmps_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(kmps_pkg::QDepth));
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rp_q];

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= cmd_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

  `KMP_ASSERT(a_cnt_range, cnt_q <= 2'(kmps_pkg::QDepth), "queue count out of range")
  `KMP_ASSERT(a_no_pop_empty, empty_o |=> cnt_q <= 2'd1, "queue count jumped")
  `KMP_ASSERT(a_ptr_eq, empty_o |-> wp_q == rp_q, "pointers differ when empty")
endmodule
`default_nettype wire

### rtl/kmps_engine.sv
// back end: pattern store, table build and text matching
`default_nettype none
module kmps_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           avail_i,
  input  kmps_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  input  wire logic [7:0]     start_pos_i,
  output logic                res_valid_o,
  output logic                found_o,
  output logic [7:0]          match_index_o
);
  `include "kmp_substring_search_top_defines.svh"
  localparam int unsigned IW = kmps_pkg::IdxW;
  localparam int unsigned LW = kmps_pkg::LenW;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SBRd   = 3'd1;
  localparam logic [2:0] SBCmp  = 3'd2;
  localparam logic [2:0] SBWr   = 3'd3;
  localparam logic [2:0] STRd   = 3'd4;
  localparam logic [2:0] STCmp  = 3'd5;
  localparam logic [2:0] SBRw   = 3'd6;

  logic [2:0] st_q;
  logic [7:0] pat_mem [kmps_pkg::MaxLen];
  logic [LW-1:0] fail_mem [kmps_pkg::MaxLen];
  logic [LW-1:0] plen_q, ms_q, tpos_q, a_q, b_q;
  logic rdy_q, done_q;
  logic [7:0] first_q, c_q;
  // registered memory reads
  logic [7:0] pa_q, pb_q;
  logic [LW-1:0] fb_q;
  logic [IW-1:0] rd_a, rd_b;
  logic pw_en, fw_en;
  logic [IW-1:0] pw_addr, fw_addr;
  logic [LW-1:0] fw_data;

  // read addresses: build indexes, or the match state in a text step
  assign rd_a = a_q[IW-1:0];
  assign rd_b = (st_q == STRd) ? ms_q[IW-1:0] : b_q[IW-1:0];

  // memories: one write and registered reads
  always_ff @(posedge clk_i) begin
    if (pw_en) pat_mem[pw_addr] <= cmd_i.data;
    if (fw_en) fail_mem[fw_addr] <= fw_data;
    pa_q <= pat_mem[rd_a];
    pb_q <= pat_mem[rd_b];
    fb_q <= fail_mem[rd_b];
  end

  wire logic [LW-1:0] a1 = a_q + 1'b1;
  wire logic [LW-1:0] b1 = b_q + 1'b1;
  wire logic b_neg = b_q[LW-1] & (b_q == '1);
  wire logic m_neg = (ms_q == '1);

  always_comb begin
    pw_en = 1'b0; pw_addr = plen_q[IW-1:0];
    fw_en = 1'b0; fw_addr = a_q[IW-1:0]; fw_data = b_q;
    if (st_q == SIdle && avail_i && cmd_i.func == kmps_pkg::FuncPat &&
        plen_q < LW'(kmps_pkg::MaxLen)) pw_en = 1'b1;
    if (st_q == SIdle && avail_i && cmd_i.func == kmps_pkg::FuncText && !rdy_q &&
        plen_q != '0) begin
      fw_en = 1'b1; fw_addr = '0; fw_data = '1;
    end
    if (st_q == SBWr) begin
      fw_en = 1'b1;
      fw_data = (pa_q != pb_q) ? b_q : fb_q;
    end
  end

  assign pop_o = (st_q == SIdle) && avail_i;

  // command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; plen_q <= '0; rdy_q <= 1'b0; ms_q <= '0; tpos_q <= '0;
      done_q <= 1'b0; first_q <= '0; res_valid_o <= 1'b0; found_o <= 1'b0;
      match_index_o <= '0; a_q <= '0; b_q <= '0; c_q <= '0;
    end else begin
      res_valid_o <= 1'b0;
      unique case (st_q)
        SIdle: if (avail_i) begin
          unique case (cmd_i.func)
            kmps_pkg::FuncClear, kmps_pkg::FuncPat: begin
              if (cmd_i.func == kmps_pkg::FuncClear) plen_q <= '0;
              else if (plen_q < LW'(kmps_pkg::MaxLen)) plen_q <= plen_q + 1'b1;
              rdy_q <= 1'b0; ms_q <= '0; tpos_q <= '0; done_q <= 1'b0; first_q <= '0;
            end
            kmps_pkg::FuncText: begin
              c_q <= cmd_i.data;
              if (!rdy_q && plen_q != '0) begin
                a_q <= '0; b_q <= '1;
                if (plen_q == LW'(1)) begin
                  rdy_q <= 1'b1; st_q <= STRd;
                end else st_q <= SBRd;
              end else st_q <= STRd;
            end
            default: begin
              res_valid_o <= 1'b1;
              if (plen_q == '0) begin
                found_o <= 1'b1; match_index_o <= start_pos_i;
              end else if (done_q) begin
                found_o <= 1'b1; match_index_o <= first_q;
              end else begin
                found_o <= 1'b0; match_index_o <= '0;
              end
              ms_q <= '0; tpos_q <= '0; done_q <= 1'b0; first_q <= '0;
            end
          endcase
        end
        // build loop: read a and b entries
        SBRd: begin
          st_q <= SBCmp;
        end
        SBCmp: begin
          if (b_neg || pa_q == pb_q) begin
            a_q <= a1; b_q <= b1; st_q <= SBRw;
          end else begin
            b_q <= fb_q; st_q <= SBRd;
          end
        end
        // wait for the reads at the advanced indexes
        SBRw: begin
          st_q <= SBWr;
        end
        SBWr: begin
          if (a_q >= plen_q - 1'b1) begin
            rdy_q <= 1'b1; st_q <= STRd;
          end else st_q <= SBCmp;
        end
        // text step
        STRd: begin
          if (tpos_q >= LW'(kmps_pkg::MaxLen)) st_q <= SIdle;
          else if (tpos_q < LW'(start_pos_i) || done_q || plen_q == '0) begin
            tpos_q <= tpos_q + 1'b1; st_q <= SIdle;
          end else begin
            st_q <= STCmp;
          end
        end
        STCmp: begin
          if (m_neg || c_q == pb_q) begin
            ms_q <= ms_q + 1'b1;
            tpos_q <= tpos_q + 1'b1;
            if (ms_q + 1'b1 == plen_q) begin
              done_q <= 1'b1;
              first_q <= 8'(tpos_q + 1'b1 - plen_q);
            end
            st_q <= SIdle;
          end else begin
            ms_q <= fb_q;
            st_q <= (fb_q == '1) ? STCmp : STRd;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  `KMP_ASSERT(a_plen_max, plen_q <= LW'(kmps_pkg::MaxLen), "pattern length overflow")
  `KMP_ASSERT(a_tpos_max, tpos_q <= LW'(kmps_pkg::MaxLen), "text position overflow")
  `KMP_ASSERT(a_done_ms, done_q |-> ms_q == plen_q, "match flag without full match")
endmodule
`default_nettype wire

### rtl/kmp_substring_search_top.sv
// top level of the kmp substring search block
// the result strobe is registered when the idle engine takes end of text from the command queue
// a pattern word is stored from idle; a text word passes through STRd, then STCmp unless skipped,
// and each fallback through the failure table goes back to STRd (stays in STCmp at minus one)
// the first text word after a pattern change builds the table: SBCmp, SBRw, SBWr an entry
// reset clears control state and start position; stores hold garbage until written
`default_nettype none
module kmp_substring_search_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  output logic            done_o,
  output logic            found_o,
  output logic [7:0]      match_index_o
);
  logic [7:0] start_pos_q;
  logic full, empty, pop;
  kmps_pkg::cmd_t cmd_in, cmd_q;

  assign busy = full;
  assign cfg_ready_o = 1'b1;
  assign cmd_in.func = kmps_pkg::func_e'(func_i);
  assign cmd_in.data = data_byte_i;

  // start position register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_pos_q <= '0;
    else if (cfg_valid_i && cfg_ready_o) start_pos_q <= cfg_data_i;
  end

  kmps_front u_front (
    .clk_i, .rst_ni, .push_i(start), .cmd_i(cmd_in), .full_o(full),
    .empty_o(empty), .pop_i(pop), .cmd_o(cmd_q)
  );

  kmps_engine u_engine (
    .clk_i, .rst_ni, .avail_i(!empty), .cmd_i(cmd_q), .pop_o(pop),
    .start_pos_i(start_pos_q), .res_valid_o(done_o),
    .found_o, .match_index_o
  );
endmodule
`default_nettype wire

### tb/kmp_substring_search_top_tb.sv
// testbench for the kmp substring search block: predicted search results vs. rtl
`timescale 1ns / 100ps
`default_nettype none
module kmp_substring_search_top_tb;

  localparam int unsigned StallLimit = 40000;

  // predictor of the search and store of expected match results
  class kmp_scoreboard;
    bit [7:0]   pat_mem[kmps_pkg::MaxLen];
    int         fail_tab[kmps_pkg::MaxLen];
    int         pat_len;
    bit         tab_built;
    int         cur_state;
    int         txt_pos;
    bit         hit;
    int         hit_idx;
    bit [7:0]   start_pos;
    bit         want_found[$];
    bit [7:0]   want_idx[$];
    int         errors;

    function void clear_search();
      cur_state = 0;
      txt_pos   = 0;
      hit       = 0;
      hit_idx   = 0;
    endfunction

    function void reset_all();
      pat_len   = 0;
      tab_built = 0;
      start_pos = 0;
      errors    = 0;
      clear_search();
    endfunction

    // nextval failure table from the stored pattern
    function void build_fail_tab();
      int a;
      int b;
      a = 0;
      b = -1;
      fail_tab[0] = -1;
      while (a < pat_len - 1) begin
        if (b == -1 || pat_mem[a] == pat_mem[b]) begin
          a++;
          b++;
          if (pat_mem[a] != pat_mem[b]) fail_tab[a] = b;
          else fail_tab[a] = fail_tab[b];
        end else begin
          b = fail_tab[b];
        end
      end
      tab_built = 1;
    endfunction

    function void scan_char(bit [7:0] c);
      int idx;
      idx = txt_pos;
      if (idx >= kmps_pkg::MaxLen) return;
      txt_pos = idx + 1;
      if (idx < start_pos || hit || pat_len == 0) return;
      forever begin
        if (cur_state < 0 || c == pat_mem[cur_state]) begin
          cur_state++;
          break;
        end
        cur_state = fail_tab[cur_state];
      end
      if (cur_state == pat_len) begin
        hit     = 1;
        hit_idx = idx + 1 - pat_len;
      end
    endfunction

    // note one accepted command word
    function void note_cmd(kmps_pkg::func_e f, bit [7:0] d);
      case (f)
        kmps_pkg::FuncClear: begin
          pat_len   = 0;
          tab_built = 0;
          clear_search();
        end
        kmps_pkg::FuncPat: begin
          if (pat_len < kmps_pkg::MaxLen) begin
            pat_mem[pat_len] = d;
            pat_len++;
          end
          tab_built = 0;
          clear_search();
        end
        kmps_pkg::FuncText: begin
          if (!tab_built && pat_len > 0) build_fail_tab();
          scan_char(d);
        end
        default: begin
          if (pat_len == 0) begin
            want_found.push_back(1'b1);
            want_idx.push_back(start_pos);
          end else if (hit) begin
            want_found.push_back(1'b1);
            want_idx.push_back(hit_idx[7:0]);
          end else begin
            want_found.push_back(1'b0);
            want_idx.push_back(8'd0);
          end
          clear_search();
        end
      endcase
    endfunction

    // compare one result word with the oldest expectation
    function void check_result(bit fo, bit [7:0] mi);
      bit       ef;
      bit [7:0] ei;
      if (want_found.size() == 0) begin
        $error("unexpected result found=%0d match_index=%0d", fo, mi);
        errors++;
        return;
      end
      ef = want_found.pop_front();
      ei = want_idx.pop_front();
      if (fo !== ef) begin
        $error("found: expected %0d, actual %0d", ef, fo);
        errors++;
      end
      if (mi !== ei) begin
        $error("match_index: expected %0d, actual %0d", ei, mi);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] func_i;
  logic [7:0] data_byte_i;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;
  logic       done_o;
  logic       found_o;
  logic [7:0] match_index_o;

  kmp_scoreboard sb;
  bit            no_idle;
  int            stall_cnt;
  int            n_items;

  kmp_substring_search_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .match_index_o(match_index_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(found_o, match_index_o);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // send one command word, with random idle burst ahead of it
  task automatic send_cmd(kmps_pkg::func_e f, bit [7:0] d);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start       = 1'b1;
    func_i      = f;
    data_byte_i = d;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_cmd(f, d);
    n_items++;
  endtask

  // release start and let all pending results arrive
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.want_found.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  // write start position while idle
  task automatic write_start(bit [7:0] v);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.start_pos = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = 8'($urandom);
  endtask

  // one search: pattern and text from a small alphabet, pattern planted at times
  task automatic run_search(int plen, int tlen);
    bit [7:0] alpha[3];
    bit [7:0] p[$];
    int       at;
    foreach (alpha[k]) alpha[k] = 8'($urandom);
    send_cmd(kmps_pkg::FuncClear, 8'($urandom));
    for (int k = 0; k < plen; k++) begin
      p.push_back(alpha[$urandom_range(0, 1 + ($urandom_range(0, 3) == 0))]);
      send_cmd(kmps_pkg::FuncPat, p[k]);
    end
    at = ($urandom_range(0, 2) != 0) ? $urandom_range(0, tlen) : -1;
    for (int k = 0; k < tlen; k++) begin
      if (at >= 0 && k >= at && k < at + plen) send_cmd(kmps_pkg::FuncText, p[k - at]);
      else send_cmd(kmps_pkg::FuncText, alpha[$urandom_range(0, 2)]);
      // occasional noise word in the middle of the text
      if ($urandom_range(0, 60) == 0) begin
        send_cmd(kmps_pkg::func_e'($urandom_range(0, 1)), 8'($urandom));
      end
    end
    send_cmd(kmps_pkg::FuncEnd, 8'($urandom));
  endtask

  initial begin
    sb = new();
    sb.reset_all();
    rst_ni      = 1'b0;
    start       = 1'b0;
    func_i      = kmps_pkg::FuncClear;
    data_byte_i = 8'd0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 8'd0;
    no_idle     = 0;
    n_items     = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty pattern matches at start position
    send_cmd(kmps_pkg::FuncEnd, 8'hff);
    send_cmd(kmps_pkg::FuncText, 8'h00);
    send_cmd(kmps_pkg::FuncEnd, 8'h00);
    // simple match with extreme bytes
    send_cmd(kmps_pkg::FuncPat, 8'h00);
    send_cmd(kmps_pkg::FuncPat, 8'hff);
    send_cmd(kmps_pkg::FuncText, 8'hff);
    send_cmd(kmps_pkg::FuncText, 8'h00);
    send_cmd(kmps_pkg::FuncText, 8'hff);
    send_cmd(kmps_pkg::FuncEnd, 8'h55);
    // pattern change mid-text restarts the search
    send_cmd(kmps_pkg::FuncText, 8'h00);
    send_cmd(kmps_pkg::FuncPat, 8'haa);
    send_cmd(kmps_pkg::FuncText, 8'haa);
    send_cmd(kmps_pkg::FuncText, 8'h00);
    send_cmd(kmps_pkg::FuncClear, 8'haa);
    send_cmd(kmps_pkg::FuncPat, 8'h00);
    send_cmd(kmps_pkg::FuncText, 8'h00);
    send_cmd(kmps_pkg::FuncEnd, 8'h00);
    // start beyond text: not found; empty pattern still reports start
    write_start(8'd255);
    send_cmd(kmps_pkg::FuncText, 8'h00);
    send_cmd(kmps_pkg::FuncEnd, 8'h00);
    send_cmd(kmps_pkg::FuncClear, 8'h00);
    send_cmd(kmps_pkg::FuncEnd, 8'h00);
    write_start(8'd1);
    run_search(2, 6);

    // pattern and text overflow
    write_start(8'd0);
    run_search(kmps_pkg::MaxLen + 3, kmps_pkg::MaxLen + 4);

    // random searches over several start positions
    while (n_items < 1450) begin
      case ($urandom_range(0, 5))
        0:       write_start(8'd0);
        1:       write_start(8'd255);
        2:       write_start(8'($urandom));
        default: write_start(8'($urandom_range(0, 12)));
      endcase
      repeat (6) begin
        if (n_items < 1450) begin
          if (n_items > 1250) no_idle = 1;
          if ($urandom_range(0, 8) == 0) begin
            send_cmd(kmps_pkg::func_e'($urandom_range(0, 3)), 8'($urandom));
          end
          run_search($urandom_range(0, 5), $urandom_range(0, 30));
        end
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.want_found.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/kmps_pkg.sv
rtl/kmps_front.sv
rtl/kmps_engine.sv
rtl/kmp_substring_search_top.sv
tb/kmp_substring_search_top_tb.sv
